// ===== sv/ffea_pkg.sv =====
// shared constants and types of the first-fit extent allocator
`timescale 1ns / 1ps
package ffea_pkg;
   localparam int Extents = 16;
   localparam int IdxW = $clog2(Extents);
   localparam int CntW = $clog2(Extents + 1);
   localparam int AddrBits = 32;
   localparam logic [31:0] MinExtent = 32'd8;

   // configuration register indexes
   localparam logic RegHeapBase = 1'b0;
   localparam logic RegHeapEnd = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE = 2'd1,
      OP_INIT = 2'd2,
      OP_NOP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_SMALL = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // latch request
      logic clr_scan;      // scan index to zero
      logic inc_scan;      // step scan index
      logic rd;            // read entry at scan index
      logic rd_prev;       // read entry at scan index minus one
      logic cap_prev;      // register read data as previous neighbour
      logic cap_next;      // register read data as next neighbour
      logic do_init;
      logic alloc_take;    // alloc: shrink or drop entry at scan
      logic free_commit;   // release: apply merge decision
      logic shift_up;      // move entry k-1 to k, k counts down
      logic shift_dn;      // move entry k+1 to k, k counts up
      logic set_status;
      status_type st;
      logic out_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;      // scan index at used count
      logic fits;          // entry read fits request
      logic start_le;      // entry read start <= addr
      logic size_small;
      logic init_bad;
      logic full;
      logic merge_any;
      logic merge_next_only_prev; // both merges
      logic drop_pending;  // alloc removes the entry
      logic mv_done;       // shift pointer reached target
      logic dn_last;       // last move of an entry removal
   } sts_type;
endpackage

// ===== sv/first_fit_extent_allocator.sv =====
// top level of the first-fit free-extent allocator
//
// channel  direction  handshake           payload
// req      in         req_valid/req_stall opcode, req_size, extent_addr
// rsp      out        rsp_valid/rsp_stall status, grant_addr, free_bytes, extent_count
// csr      in         csr_valid/csr_ready index 0 heap_base, 1 heap_end
//
// one beat at a time; a request passes the accept, decode and result states, plus a read
// and a check per table entry scanned, a further read when a scan runs off the table end,
// read, capture and commit states for a release's merge step, and a move per entry moved
// the single-ported extent table allows one read or move a cycle
// reset is synchronous and clears counts; table entries need no reset
// the result register holds its beat while rsp_stall is high, and a finished
// request waits in its last cycle until that beat has left
`timescale 1ns / 1ps
module first_fit_extent_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_extent_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_grant_addr,
   output logic [31:0] rsp_free_bytes,
   output logic [4:0]  rsp_extent_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] heap_base_ff, heap_end_ff;
   logic busy;
   ffea_pkg::ctl_type ctl;
   ffea_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // heap bounds registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_end_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == ffea_pkg::RegHeapEnd) begin
            heap_end_ff <= csr_data;
         end else begin
            heap_base_ff <= csr_data;
         end
      end
   end

   ffea_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_opcode,
      .rsp_valid, .rsp_stall, .busy, .ctl, .sts
   );

   ffea_datapath u_dp (
      .clock, .reset, .ctl, .sts,
      .heap_base(heap_base_ff), .heap_end(heap_end_ff),
      .req_req_size, .req_extent_addr,
      .rsp_status, .rsp_grant_addr, .rsp_free_bytes, .rsp_extent_count
   );

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("accepting while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("beat dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_free_bytes))
      else $error("stalled beat changed");
`endif
endmodule

// ===== sv/ffea_datapath.sv =====
// extent table, scan pointer, merge arithmetic and result register
`timescale 1ns / 1ps
module ffea_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ffea_pkg::ctl_type      ctl,
   output ffea_pkg::sts_type      sts,
   input  logic [31:0]            heap_base,
   input  logic [31:0]            heap_end,
   input  logic [31:0]            req_req_size,
   input  logic [31:0]            req_extent_addr,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_grant_addr,
   output logic [31:0]            rsp_free_bytes,
   output logic [4:0]             rsp_extent_count
);
   localparam int IW = ffea_pkg::IdxW;
   localparam int CW = ffea_pkg::CntW;

   logic [31:0] start_mem [ffea_pkg::Extents];
   logic [31:0] len_mem [ffea_pkg::Extents];

   logic [31:0] size_ff, addr_ff;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] mv_ff, mv_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] rs_ff, rl_ff;             // registered read data
   logic [31:0] ps_ff, pl_ff, ns_ff, nl_ff;
   logic        pv_ff, nv_ff;
   logic [31:0] grant_ff, grant_in;
   logic [1:0]  st_ff;
   logic [1:0]  st_res_ff, st_res_in;
   logic        mp, mn;
   logic [32:0] psum, pl_add, cur_end, nl_add;
   logic [31:0] cur_start, cur_len;
   logic [31:0] span;
   logic [31:0] rem;
   logic [IW-1:0] rd_idx;

   assign psum = {1'b0, ps_ff} + {1'b0, pl_ff};
   assign pl_add = {1'b0, pl_ff} + {1'b0, size_ff};
   assign mp = pv_ff && psum == {1'b0, addr_ff} && !pl_add[32];
   assign cur_start = mp ? ps_ff : addr_ff;
   assign cur_len = mp ? pl_add[31:0] : size_ff;
   assign cur_end = {1'b0, cur_start} + {1'b0, cur_len};
   assign nl_add = {1'b0, cur_len} + {1'b0, nl_ff};
   assign mn = nv_ff && cur_end == {1'b0, ns_ff} && !nl_add[32];
   assign span = heap_end - heap_base;
   assign rem = rl_ff - size_ff;

   assign sts.scan_end = scan_ff == used_ff;
   assign sts.fits = rl_ff >= size_ff;
   assign sts.start_le = rs_ff <= addr_ff;
   assign sts.size_small = size_ff < ffea_pkg::MinExtent;
   assign sts.init_bad = heap_end <= heap_base || span < ffea_pkg::MinExtent;
   assign sts.full = used_ff == CW'(ffea_pkg::Extents);
   assign sts.merge_any = mp || mn;
   assign sts.merge_next_only_prev = mp && mn;
   assign sts.drop_pending = rem < ffea_pkg::MinExtent;
   assign sts.mv_done = mv_ff == scan_ff;
   assign sts.dn_last = mv_ff + CW'(1) >= used_ff - CW'(1);

   always_comb begin
      rd_idx = scan_ff[IW-1:0];
      if (ctl.rd_prev) begin
         rd_idx = IW'(scan_ff - CW'(1));
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (ctl.clr_scan) begin
         scan_in = '0;
      end else if (ctl.inc_scan) begin
         scan_in = scan_ff + CW'(1);
      end
   end

   always_comb begin
      used_in = used_ff;
      total_in = total_ff;
      grant_in = grant_ff;
      mv_in = mv_ff;
      st_res_in = st_res_ff;
      if (ctl.load) begin
         grant_in = '0;
      end
      if (ctl.do_init) begin
         used_in = sts.init_bad ? '0 : CW'(1);
         total_in = sts.init_bad ? '0 : span;
      end
      if (ctl.alloc_take) begin
         grant_in = rs_ff;
         if (sts.drop_pending) begin
            total_in = total_ff - rl_ff;
            mv_in = scan_ff;
         end else begin
            total_in = total_ff - size_ff;
         end
      end
      if (ctl.free_commit) begin
         total_in = total_ff + size_ff;
         if (!mp && !mn) begin
            used_in = used_ff + CW'(1);
            mv_in = used_ff;
         end else if (mp && mn) begin
            mv_in = scan_ff;
         end
      end
      if (ctl.shift_up) begin
         mv_in = mv_ff - CW'(1);
      end
      if (ctl.shift_dn) begin
         if (sts.dn_last) begin
            used_in = used_ff - CW'(1);
            mv_in = scan_ff;
         end else begin
            mv_in = mv_ff + CW'(1);
         end
      end
      if (ctl.set_status) begin
         st_res_in = ctl.st;
      end
   end

   // table writes: one port, chosen by the controller command
   always_ff @(posedge clock) begin
      if (ctl.do_init && !sts.init_bad) begin
         start_mem[0] <= heap_base;
         len_mem[0] <= span;
      end else if (ctl.alloc_take && !sts.drop_pending) begin
         start_mem[scan_ff[IW-1:0]] <= rs_ff + size_ff;
         len_mem[scan_ff[IW-1:0]] <= rem;
      end else if (ctl.free_commit && (mp || mn)) begin
         if (mp) begin
            start_mem[IW'(scan_ff - CW'(1))] <= cur_start;
            len_mem[IW'(scan_ff - CW'(1))] <= mn ? nl_add[31:0] : cur_len;
         end else begin
            start_mem[scan_ff[IW-1:0]] <= cur_start;
            len_mem[scan_ff[IW-1:0]] <= nl_add[31:0];
         end
      end else if (ctl.shift_up) begin
         if (mv_ff == scan_ff) begin
            start_mem[scan_ff[IW-1:0]] <= addr_ff;
            len_mem[scan_ff[IW-1:0]] <= size_ff;
         end else begin
            start_mem[mv_ff[IW-1:0]] <= start_mem[IW'(mv_ff - CW'(1))];
            len_mem[mv_ff[IW-1:0]] <= len_mem[IW'(mv_ff - CW'(1))];
         end
      end else if (ctl.shift_dn) begin
         start_mem[mv_ff[IW-1:0]] <= start_mem[IW'(mv_ff + CW'(1))];
         len_mem[mv_ff[IW-1:0]] <= len_mem[IW'(mv_ff + CW'(1))];
      end
      if (ctl.rd || ctl.rd_prev) begin
         rs_ff <= start_mem[rd_idx];
         rl_ff <= len_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         total_ff <= '0;
         scan_ff <= '0;
         mv_ff <= '0;
         pv_ff <= 1'b0;
         nv_ff <= 1'b0;
         st_res_ff <= ffea_pkg::ST_OK;
         st_ff <= ffea_pkg::ST_OK;
      end else begin
         used_ff <= used_in;
         total_ff <= total_in;
         scan_ff <= scan_in;
         mv_ff <= mv_in;
         st_res_ff <= st_res_in;
         if (ctl.load) begin
            pv_ff <= 1'b0;
            nv_ff <= 1'b0;
         end
         // no entry below when the insert point is the table head
         if (ctl.cap_prev) begin
            pv_ff <= (scan_ff != '0);
         end
         if (ctl.cap_next) begin
            nv_ff <= 1'b1;
         end
         if (ctl.out_load) begin
            st_ff <= st_res_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      grant_ff <= grant_in;
      if (ctl.load) begin
         size_ff <= req_req_size;
         addr_ff <= req_extent_addr;
      end
      if (ctl.cap_prev) begin
         ps_ff <= rs_ff;
         pl_ff <= rl_ff;
      end
      if (ctl.cap_next) begin
         ns_ff <= rs_ff;
         nl_ff <= rl_ff;
      end
      if (ctl.out_load) begin
         rsp_grant_addr <= grant_ff;
         rsp_free_bytes <= total_ff;
         rsp_extent_count <= 5'(used_ff);
      end
   end

   assign rsp_status = st_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(ffea_pkg::Extents)) else $error("used count overflow");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= used_ff) else $error("scan past table");
   a_init_count: assert property (@(posedge clock) disable iff (reset)
      ctl.do_init |=> used_ff <= CW'(1)) else $error("init count");
`endif
endmodule

// ===== sv/ffea_ctrl.sv =====
// request sequencer of the extent allocator
`timescale 1ns / 1ps
module ffea_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  busy,
   output ffea_pkg::ctl_type     ctl,
   input  ffea_pkg::sts_type     sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD, S_CHK, S_RD_PREV, S_CAP_PREV,
      S_COMMIT, S_SHIFT_UP, S_SHIFT_DN, S_DONE
   } state_type;

   state_type state_ff;
   logic [1:0] op_ff;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign busy = state_ff != S_IDLE;

   always_comb begin
      ctl = '0;
      ctl.st = ffea_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               ctl.clr_scan = 1'b1;
            end
         end
         S_DECODE: begin
            ctl.set_status = 1'b1;
            unique case (ffea_pkg::opcode_type'(op_ff))
               ffea_pkg::OP_INIT: begin
                  ctl.do_init = 1'b1;
                  ctl.st = sts.init_bad ? ffea_pkg::ST_SMALL : ffea_pkg::ST_OK;
               end
               ffea_pkg::OP_NOP: ctl.st = ffea_pkg::ST_OK;
               default: begin
                  if (sts.size_small) begin
                     ctl.st = ffea_pkg::ST_SMALL;
                  end else if (!sts.scan_end) begin
                     ctl.rd = 1'b1;
                  end else if (op_ff == ffea_pkg::OP_ALLOC) begin
                     ctl.st = ffea_pkg::ST_NO_FIT;
                  end
               end
            endcase
         end
         S_RD: begin
            // read the entry at the scan index; at the table end an alloc stops, a release goes to its merge step
            if (!sts.scan_end) begin
               ctl.rd = 1'b1;
            end else if (op_ff == ffea_pkg::OP_ALLOC) begin
               ctl.set_status = 1'b1;
               ctl.st = ffea_pkg::ST_NO_FIT;
            end
         end
         S_CHK: begin
            if (op_ff == ffea_pkg::OP_ALLOC) begin
               if (sts.fits) begin
                  ctl.alloc_take = 1'b1;
               end else begin
                  ctl.inc_scan = 1'b1;
               end
            end else if (sts.start_le) begin
               ctl.inc_scan = 1'b1;
            end else begin
               ctl.cap_next = 1'b1;
            end
         end
         S_RD_PREV: ctl.rd_prev = 1'b1;
         S_CAP_PREV: ctl.cap_prev = 1'b1;
         S_COMMIT: begin
            if (!sts.merge_any && sts.full) begin
               ctl.set_status = 1'b1;
               ctl.st = ffea_pkg::ST_FULL;
            end else begin
               ctl.free_commit = 1'b1;
            end
         end
         S_SHIFT_UP: ctl.shift_up = 1'b1;
         S_SHIFT_DN: ctl.shift_dn = 1'b1;
         S_DONE: ctl.out_load = out_free;
         default: ;
      endcase
   end

   // next state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= ffea_pkg::OP_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_opcode;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (ctl.rd) begin
                  state_ff <= S_RD;
               end else if (op_ff == ffea_pkg::OP_FREE && !sts.size_small) begin
                  state_ff <= S_RD_PREV; // empty table
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_RD: begin
               if (!sts.scan_end) begin
                  state_ff <= S_CHK;
               end else if (op_ff == ffea_pkg::OP_ALLOC) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_RD_PREV;
               end
            end
            S_CHK: begin
               if (op_ff == ffea_pkg::OP_ALLOC) begin
                  if (sts.fits) begin
                     state_ff <= sts.drop_pending ? S_SHIFT_DN : S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else begin
                  state_ff <= sts.start_le ? S_RD : S_RD_PREV;
               end
            end
            S_RD_PREV: state_ff <= S_CAP_PREV;
            S_CAP_PREV: state_ff <= S_COMMIT;
            S_COMMIT: begin
               if (!sts.merge_any) begin
                  state_ff <= sts.full ? S_DONE : S_SHIFT_UP;
               end else if (sts.merge_next_only_prev) begin
                  state_ff <= S_SHIFT_DN;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SHIFT_UP: if (sts.mv_done) state_ff <= S_DONE;
            S_SHIFT_DN: if (sts.dn_last) state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> rsp_valid_ff)
      else $error("result lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.alloc_take, ctl.free_commit, ctl.shift_up, ctl.shift_dn, ctl.do_init}))
      else $error("two table writes");
`endif
endmodule
